// ===== design/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB byte conversion package
// Shared widths, arithmetic constants and the hue sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEVEL_W  = 16;
    localparam int PROD_W   = 24;
    localparam int HUE6_W   = 11;

    localparam logic [BYTE_W-1:0]  BYTE_FULL  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 16'd65025;

    // Reciprocal of 65025 scaled by two to the power of 26, rounded down.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = PROD_W + 11;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

endpackage

`default_nettype wire

// ===== design/hsvrgb_hsv_if.sv =====
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid and ready handshake carrying one HSV pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_hsv_if;

    logic                             valid;
    logic                             ready;
    logic [hsvrgb_pkg::BYTE_W-1:0]    hue;
    logic [hsvrgb_pkg::BYTE_W-1:0]    saturation;
    logic [hsvrgb_pkg::BYTE_W-1:0]    brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);

endinterface

`default_nettype wire

// ===== design/hsvrgb_rgb_if.sv =====
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid and ready handshake carrying one RGB pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_rgb_if;

    logic                             valid;
    logic                             ready;
    logic [hsvrgb_pkg::BYTE_W-1:0]    red;
    logic [hsvrgb_pkg::BYTE_W-1:0]    green;
    logic [hsvrgb_pkg::BYTE_W-1:0]    blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);

endinterface

`default_nettype wire

// ===== design/hsvrgb_div65025.sv =====
// ----------------------------------------------------------------------------
// Division by 65025 stage
// Registers a reciprocal estimate of the quotient and corrects it by one.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_div65025 (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [hsvrgb_pkg::PROD_W-1:0]      dividend,
    output logic      [hsvrgb_pkg::BYTE_W-1:0]      quotient
);

    logic [hsvrgb_pkg::RECIP_W-1:0] scaled;
    logic [hsvrgb_pkg::PROD_W-1:0]  dividend_reg;
    logic [hsvrgb_pkg::BYTE_W-1:0]  est_reg;
    logic [hsvrgb_pkg::BYTE_W-1:0]  est_next;
    logic [hsvrgb_pkg::PROD_W:0]    back;
    logic [hsvrgb_pkg::PROD_W:0]    rem;

    // The estimate is the true quotient or one less.
    always_comb
    begin
        scaled = ({{(hsvrgb_pkg::RECIP_W-hsvrgb_pkg::PROD_W){1'b0}}, dividend} << 10)
               + ({{(hsvrgb_pkg::RECIP_W-hsvrgb_pkg::PROD_W){1'b0}}, dividend} << 3);
        est_next = scaled[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::BYTE_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dividend_reg <= dividend;
            est_reg      <= est_next;
        end
    end

    always_comb
    begin
        back = ({{(hsvrgb_pkg::PROD_W+1-hsvrgb_pkg::BYTE_W){1'b0}}, est_reg} << 16)
             - ({{(hsvrgb_pkg::PROD_W+1-hsvrgb_pkg::BYTE_W){1'b0}}, est_reg} << 9)
             + {{(hsvrgb_pkg::PROD_W+1-hsvrgb_pkg::BYTE_W){1'b0}}, est_reg};
        rem  = {1'b0, dividend_reg} - back;
        if (rem >= {{(hsvrgb_pkg::PROD_W+1-hsvrgb_pkg::LEVEL_W){1'b0}},
                    hsvrgb_pkg::LEVEL_ONE})
        begin
            quotient = est_reg + 8'd1;
        end
        else
        begin
            quotient = est_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/hsv_to_rgb_byte_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB byte conversion
// Six stage pipeline converting one HSV pixel to one RGB pixel.
// ----------------------------------------------------------------------------
//  Channel  Direction  Fields                              Handshake
//  hsv      in         hue, saturation, brightness         valid / ready
//  rgb      out        red, green, blue                    valid / ready
//
//  One item is accepted per cycle while the pipeline is not stalled, and each result
//  passes through the six register stages from sector split to channel mux before
//  it is on the output.
//  Reset clears the stage valid bits only; the data registers need none.
//  Each stage holds while the stage after it is full and stalled, so bubbles
//  still close up and an item is accepted while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_byte_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hsvrgb_hsv_if.sink    hsv,
    hsvrgb_rgb_if.source  rgb
);

    localparam int BW = hsvrgb_pkg::BYTE_W;
    localparam int LW = hsvrgb_pkg::LEVEL_W;
    localparam int PW = hsvrgb_pkg::PROD_W;
    localparam int HW = hsvrgb_pkg::HUE6_W;

    logic en1, en2, en3, en4, en5, en6;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage one: sector and fraction.
    logic [HW-1:0]         hue6;
    hsvrgb_pkg::sector_t   sec_next;
    logic [HW-1:0]         base;
    logic [BW-1:0]         f_next;
    hsvrgb_pkg::sector_t   sec1_reg;
    logic [BW-1:0]         f1_reg, s1_reg, b1_reg;
    logic                  zero1_reg;

    // Stage two: products.
    hsvrgb_pkg::sector_t   sec2_reg;
    logic [LW-1:0]         sf2_reg, sfc2_reg, pnum2_reg;
    logic [BW-1:0]         b2_reg;
    logic                  zero2_reg;

    // Stage three: level numerators and p.
    logic [LW-1:0]         psum;
    hsvrgb_pkg::sector_t   sec3_reg;
    logic [LW-1:0]         qn3_reg, tn3_reg;
    logic [BW-1:0]         p3_reg, b3_reg;
    logic                  zero3_reg;

    // Stage four: scaled products.
    hsvrgb_pkg::sector_t   sec4_reg;
    logic [PW-1:0]         yq4_reg, yt4_reg;
    logic [BW-1:0]         p4_reg, b4_reg;
    logic                  zero4_reg;

    // Stage five: quotient estimates.
    hsvrgb_pkg::sector_t   sec5_reg;
    logic [BW-1:0]         p5_reg, b5_reg;
    logic                  zero5_reg;
    logic [BW-1:0]         q_level, t_level;

    // Stage six: output.
    logic [BW-1:0]         r_next, g_next, bl_next;
    logic [BW-1:0]         r6_reg, g6_reg, bl6_reg;

    assign en6 = !v6_reg || rgb.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign hsv.ready = en1;
    assign rgb.valid = v6_reg;
    assign rgb.red   = r6_reg;
    assign rgb.green = g6_reg;
    assign rgb.blue  = bl6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= hsv.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // A full-circle hue wraps to the first sector with no fraction.
    always_comb
    begin
        hue6 = ({{(HW-BW){1'b0}}, hsv.hue} << 2) + ({{(HW-BW){1'b0}}, hsv.hue} << 1);
        if (hsv.hue == hsvrgb_pkg::BYTE_FULL)
        begin
            sec_next = hsvrgb_pkg::SECTOR_0;
            base     = hue6;
        end
        else if (hue6 >= 11'd1275)
        begin
            sec_next = hsvrgb_pkg::SECTOR_5;
            base     = 11'd1275;
        end
        else if (hue6 >= 11'd1020)
        begin
            sec_next = hsvrgb_pkg::SECTOR_4;
            base     = 11'd1020;
        end
        else if (hue6 >= 11'd765)
        begin
            sec_next = hsvrgb_pkg::SECTOR_3;
            base     = 11'd765;
        end
        else if (hue6 >= 11'd510)
        begin
            sec_next = hsvrgb_pkg::SECTOR_2;
            base     = 11'd510;
        end
        else if (hue6 >= 11'd255)
        begin
            sec_next = hsvrgb_pkg::SECTOR_1;
            base     = 11'd255;
        end
        else
        begin
            sec_next = hsvrgb_pkg::SECTOR_0;
            base     = 11'd0;
        end
        f_next = BW'(hue6 - base);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sec1_reg  <= sec_next;
            f1_reg    <= f_next;
            s1_reg    <= hsv.saturation;
            b1_reg    <= hsv.brightness;
            zero1_reg <= (hsv.saturation == '0);
        end
        if (en2)
        begin
            sec2_reg  <= sec1_reg;
            sf2_reg   <= {{(LW-BW){1'b0}}, s1_reg} * {{(LW-BW){1'b0}}, f1_reg};
            sfc2_reg  <= {{(LW-BW){1'b0}}, s1_reg}
                       * {{(LW-BW){1'b0}}, hsvrgb_pkg::BYTE_FULL - f1_reg};
            pnum2_reg <= {{(LW-BW){1'b0}}, b1_reg}
                       * {{(LW-BW){1'b0}}, hsvrgb_pkg::BYTE_FULL - s1_reg};
            b2_reg    <= b1_reg;
            zero2_reg <= zero1_reg;
        end
        if (en3)
        begin
            sec3_reg  <= sec2_reg;
            qn3_reg   <= hsvrgb_pkg::LEVEL_ONE - sf2_reg;
            tn3_reg   <= hsvrgb_pkg::LEVEL_ONE - sfc2_reg;
            p3_reg    <= psum[LW-1:BW];
            b3_reg    <= b2_reg;
            zero3_reg <= zero2_reg;
        end
        if (en4)
        begin
            sec4_reg  <= sec3_reg;
            yq4_reg   <= {{(PW-LW){1'b0}}, qn3_reg} * {{(PW-BW){1'b0}}, b3_reg};
            yt4_reg   <= {{(PW-LW){1'b0}}, tn3_reg} * {{(PW-BW){1'b0}}, b3_reg};
            p4_reg    <= p3_reg;
            b4_reg    <= b3_reg;
            zero4_reg <= zero3_reg;
        end
        if (en5)
        begin
            sec5_reg  <= sec4_reg;
            p5_reg    <= p4_reg;
            b5_reg    <= b4_reg;
            zero5_reg <= zero4_reg;
        end
        if (en6)
        begin
            r6_reg  <= r_next;
            g6_reg  <= g_next;
            bl6_reg <= bl_next;
        end
    end

    // Division by 255 of a 16-bit value by the reciprocal series.
    assign psum = pnum2_reg + {{BW{1'b0}}, pnum2_reg[LW-1:BW]} + LW'(1);

    hsvrgb_div65025 u_div_q (
        .clk      (clk),
        .en       (en5),
        .dividend (yq4_reg),
        .quotient (q_level)
    );

    hsvrgb_div65025 u_div_t (
        .clk      (clk),
        .en       (en5),
        .dividend (yt4_reg),
        .quotient (t_level)
    );

    always_comb
    begin
        if (zero5_reg)
        begin
            r_next  = b5_reg;
            g_next  = b5_reg;
            bl_next = b5_reg;
        end
        else
        begin
            case (sec5_reg)
                hsvrgb_pkg::SECTOR_0:
                begin
                    r_next = b5_reg;  g_next = t_level; bl_next = p5_reg;
                end
                hsvrgb_pkg::SECTOR_1:
                begin
                    r_next = q_level; g_next = b5_reg;  bl_next = p5_reg;
                end
                hsvrgb_pkg::SECTOR_2:
                begin
                    r_next = p5_reg;  g_next = b5_reg;  bl_next = t_level;
                end
                hsvrgb_pkg::SECTOR_3:
                begin
                    r_next = p5_reg;  g_next = q_level; bl_next = b5_reg;
                end
                hsvrgb_pkg::SECTOR_4:
                begin
                    r_next = t_level; g_next = p5_reg;  bl_next = b5_reg;
                end
                default:
                begin
                    r_next = b5_reg;  g_next = p5_reg;  bl_next = q_level;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/hsv_to_rgb_byte_top_test.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB byte conversion testbench
// Drives HSV pixels through the valid/ready input channel and checks every RGB
// pixel against an integer colour conversion worked out in the bench, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsv_to_rgb_byte_top_test;

    localparam int BW = hsvrgb_pkg::BYTE_W;
    localparam int RANDOM_PIXELS = 375;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AFTER = 40;
    localparam int PHASE_LEN = 140;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BW-1:0] hue;
        logic [BW-1:0] saturation;
        logic [BW-1:0] brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [BW-1:0] red;
        logic [BW-1:0] green;
        logic [BW-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        hsv_pixel_t pixel;
        rgb_pixel_t colour;
    } conversion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hsvrgb_hsv_if hsv_ch ();
    hsvrgb_rgb_if rgb_ch ();

    hsv_to_rgb_byte_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_ch),
        .rgb   (rgb_ch)
    );

    hsv_pixel_t pixels_to_send[$];
    conversion_t colours_due[$];
    int pixels_sent = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    function automatic rgb_pixel_t convert_pixel(hsv_pixel_t px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned full;
        int unsigned one;
        int unsigned frac;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        hsvrgb_pkg::sector_t sector;
        rgb_pixel_t res;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        full = hsvrgb_pkg::BYTE_FULL;
        one = hsvrgb_pkg::LEVEL_ONE;
        if (s == 0)
        begin
            res.red = BW'(v);
            res.green = BW'(v);
            res.blue = BW'(v);
        end
        else
        begin
            sector = hsvrgb_pkg::SECTOR_0;
            frac = 0;
            if (h != full)
            begin
                sector = hsvrgb_pkg::sector_t'((6 * h) / full);
                frac = (6 * h) % full;
            end
            p = (v * (full - s)) / full;
            q = (v * (one - s * frac)) / one;
            t = (v * (one - s * (full - frac))) / one;
            case (sector)
                hsvrgb_pkg::SECTOR_0: res = {BW'(v), BW'(t), BW'(p)};
                hsvrgb_pkg::SECTOR_1: res = {BW'(q), BW'(v), BW'(p)};
                hsvrgb_pkg::SECTOR_2: res = {BW'(p), BW'(v), BW'(t)};
                hsvrgb_pkg::SECTOR_3: res = {BW'(p), BW'(q), BW'(v)};
                hsvrgb_pkg::SECTOR_4: res = {BW'(t), BW'(p), BW'(v)};
                default:              res = {BW'(v), BW'(p), BW'(q)};
            endcase
        end
        return res;
    endfunction

    function automatic int sender_idle_pct(int sent);
        if (sent < PHASE_LEN)
            return 20;
        else if (sent < 2 * PHASE_LEN)
            return 65;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int sent);
        if (sent < PHASE_LEN)
            return 65;
        else if (sent < 2 * PHASE_LEN)
            return 20;
        return 0;
    endfunction

    task automatic add_pixel(int h, int s, int v);
        hsv_pixel_t px;
        px.hue = BW'(h);
        px.saturation = BW'(s);
        px.brightness = BW'(v);
        pixels_to_send.push_back(px);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hsv_pixel_t px;
        conversion_t due;
        if (!rst_n)
        begin
            hsv_ch.valid <= 1'b0;
            hsv_ch.hue <= '0;
            hsv_ch.saturation <= '0;
            hsv_ch.brightness <= '0;
        end
        else
        begin
            if (hsv_ch.valid && hsv_ch.ready)
            begin
                due.pixel = {hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness};
                due.colour = convert_pixel(due.pixel);
                colours_due.push_back(due);
                pixels_sent <= pixels_sent + 1;
            end
            if (!hsv_ch.valid || hsv_ch.ready)
            begin
                if (pixels_to_send.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(pixels_sent))
                begin
                    px = pixels_to_send.pop_front();
                    hsv_ch.valid <= 1'b1;
                    hsv_ch.hue <= px.hue;
                    hsv_ch.saturation <= px.saturation;
                    hsv_ch.brightness <= px.brightness;
                end
                else
                begin
                    hsv_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        conversion_t due;
        rgb_pixel_t got;
        if (!rst_n)
        begin
            rgb_ch.ready <= 1'b0;
        end
        else
        begin
            if (rgb_ch.valid && rgb_ch.ready)
            begin
                got = {rgb_ch.red, rgb_ch.green, rgb_ch.blue};
                if (colours_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected RGB item %0d/%0d/%0d",
                                 got.red, got.green, got.blue);
                end
                else
                begin
                    due = colours_due.pop_front();
                    if (got !== due.colour)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("HSV %0d/%0d/%0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     due.pixel.hue, due.pixel.saturation,
                                     due.pixel.brightness, due.colour.red,
                                     due.colour.green, due.colour.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rgb_ch.ready <= 1'b0;
            end
            else if (!hold_done && pixels_sent >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rgb_ch.ready <= 1'b0;
            end
            else
            begin
                rgb_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct(pixels_sent));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int mode;
        hsv_ch.valid = 1'b0;
        hsv_ch.hue = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        rgb_ch.ready = 1'b0;

        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(100, 0, 200);
        add_pixel(255, 0, 255);
        add_pixel(255, 255, 200);
        add_pixel(255, 128, 77);
        add_pixel(0, 255, 255);
        add_pixel(42, 255, 255);
        add_pixel(43, 255, 255);
        add_pixel(85, 255, 255);
        add_pixel(127, 255, 255);
        add_pixel(128, 255, 255);
        add_pixel(170, 255, 255);
        add_pixel(212, 255, 255);
        add_pixel(213, 255, 255);
        add_pixel(254, 255, 255);
        add_pixel(30, 1, 255);
        add_pixel(200, 255, 0);
        add_pixel(150, 1, 1);
        add_pixel(64, 128, 128);
        add_pixel(191, 200, 170);
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            mode = $urandom_range(0, 9);
            case (mode)
                0: add_pixel($urandom_range(0, 255), 0, $urandom_range(0, 255));
                1: add_pixel(255, $urandom_range(0, 255), $urandom_range(0, 255));
                2: add_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                             $urandom_range(0, 1) * 255);
                default: add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255));
            endcase
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pixels_to_send.size() > 0 || hsv_ch.valid)
            @(posedge clk);
        while (colours_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && colours_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== hsv_to_rgb_byte_top.f =====
design/hsvrgb_pkg.sv
design/hsvrgb_hsv_if.sv
design/hsvrgb_rgb_if.sv
design/hsvrgb_div65025.sv
design/hsv_to_rgb_byte_top.sv
bench/hsv_to_rgb_byte_top_test.sv
